// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Each assertion is clocked on clk and
// disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/rc4kg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rc4kg_pkg;

    localparam int OP_W  = 2;
    localparam int KEY_W = 8;
    localparam int OUT_W = 8;
    localparam int CFG_W = 4;

    localparam logic [OP_W-1:0] OP_INIT = 2'd0;
    localparam logic [OP_W-1:0] OP_KEY  = 2'd1;
    localparam logic [OP_W-1:0] OP_GEN  = 2'd2;

    localparam logic [CFG_W-1:0] WORD_BITS_RESET = 4'd8;

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
    localparam logic [ST_W-1:0] ST_RD_J = 3'd1;
    localparam logic [ST_W-1:0] ST_RD_T = 3'd2;
    localparam logic [ST_W-1:0] ST_FIN  = 3'd3;
    localparam logic [ST_W-1:0] ST_FILL = 3'd4;

    typedef logic [OP_W-1:0]  op_t;
    typedef logic [KEY_W-1:0] key_t;
    typedef logic [OUT_W-1:0] ks_word_t;
    typedef logic [CFG_W-1:0] word_bits_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rc4kg_intf.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface rc4kg_in_if;
    logic              valid;
    logic              ready;
    rc4kg_pkg::op_t    op;
    rc4kg_pkg::key_t   key_word;

    modport source (output valid, output op, output key_word, input ready);
    modport sink   (input valid, input op, input key_word, output ready);
endinterface

interface rc4kg_out_if;
    logic                  valid;
    logic                  ready;
    rc4kg_pkg::ks_word_t   keystream_word;

    modport source (output valid, output keystream_word, input ready);
    modport sink   (input valid, input keystream_word, output ready);
endinterface

interface rc4kg_cfg_if;
    logic                    valid;
    logic                    ready;
    rc4kg_pkg::word_bits_t   word_bits;

    modport source (output valid, output word_bits, input ready);
    modport sink   (input valid, input word_bits, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rc4kg_perm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rc4kg_perm_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 8
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // A read of the entry being written in the same cycle returns the new word.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            if (we && (waddr == raddr))
            begin
                rdata <= wdata;
            end
            else
            begin
                rdata <= mem[raddr];
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rc4_keystream_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Role   Word                       Accepted when
// in_ch     sink   op, key_word               in_ch.valid && in_ch.ready
// out_ch    source keystream_word             out_ch.valid && out_ch.ready
// cfg       sink   word_bits                  cfg.valid && cfg.ready (always ready)
//
// A key or generate word steps through the single-port-write table: read S[i] as it is taken,
// read S[j] (ST_RD_J), write S[i] (ST_RD_T), then write S[j] (ST_FIN) while the next word is taken.
// An init word sweeps the identity into all 2^MAX_WORD_BITS entries of the table, one entry a cycle.
// Reset clears indices and phase and restores the eight-bit word size; the table holds
// no value until an init word.
// A generate word waits in ST_FIN while the output register is full and out_ch.ready is low.

module rc4_keystream_generator #(
    parameter int MAX_WORD_BITS = 8
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    rc4kg_in_if.sink    in_ch,
    rc4kg_out_if.source out_ch,
    rc4kg_cfg_if.sink   cfg
);

    `include "assert_macros.svh"

    localparam int AW = MAX_WORD_BITS;

    function automatic logic [AW-1:0] mask_for(input rc4kg_pkg::word_bits_t wb);
        rc4kg_pkg::word_bits_t n;
        logic [AW-1:0]         m;
        n = wb;
        if (n == '0)
        begin
            n = 4'd1;
        end
        if (n > rc4kg_pkg::CFG_W'(MAX_WORD_BITS))
        begin
            n = rc4kg_pkg::CFG_W'(MAX_WORD_BITS);
        end
        for (int k = 0; k < AW; k++)
        begin
            m[k] = (k < int'(n));
        end
        return m;
    endfunction

    logic [rc4kg_pkg::ST_W-1:0] state_reg;
    logic [rc4kg_pkg::ST_W-1:0] state_next;
    logic [AW-1:0] mask_reg;
    logic [AW-1:0] i_reg;
    logic [AW-1:0] j_reg;
    logic          gen_reg;
    logic [AW-1:0] i_cur_reg;
    logic [AW-1:0] si_reg;
    logic [AW-1:0] sj_reg;
    logic [AW-1:0] t_reg;
    logic [AW-1:0] key_reg;
    logic          op_gen_reg;
    logic [AW-1:0] cnt_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    rc4kg_pkg::ks_word_t out_word_reg;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [AW-1:0] mem_rdata;

    logic          accept;
    logic          finish;
    logic          do_init;
    logic          do_key;
    logic          do_gen;
    logic [AW-1:0] i_base;
    logic [AW-1:0] i_use;
    logic [AW-1:0] j_calc;
    logic [AW-1:0] t_calc;
    logic [AW-1:0] st_sel;

    rc4kg_perm_ram #(
        .ADDR_W (AW),
        .DATA_W (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign cfg.ready = 1'b1;

    assign finish = (state_reg == rc4kg_pkg::ST_FIN)
                 && (!op_gen_reg || !out_valid_reg || out_ch.ready);
    assign in_ch.ready = (state_reg == rc4kg_pkg::ST_IDLE) || finish;
    assign accept  = in_ch.valid && in_ch.ready;
    assign do_init = accept && (in_ch.op == rc4kg_pkg::OP_INIT);
    assign do_key  = accept && (in_ch.op == rc4kg_pkg::OP_KEY) && !gen_reg;
    assign do_gen  = accept && (in_ch.op == rc4kg_pkg::OP_GEN);

    // The first generate word after keying restarts both indices from zero.
    assign i_base = gen_reg ? i_reg : '0;

    always_comb
    begin
        if (in_ch.op == rc4kg_pkg::OP_GEN)
        begin
            i_use = (i_base + AW'(1)) & mask_reg;
        end
        else
        begin
            i_use = i_reg & mask_reg;
        end
    end

    always_comb
    begin
        if (op_gen_reg)
        begin
            j_calc = (j_reg + (mem_rdata & mask_reg)) & mask_reg;
        end
        else
        begin
            j_calc = (j_reg + (mem_rdata & mask_reg) + (key_reg & mask_reg)) & mask_reg;
        end
    end

    assign t_calc = ((si_reg & mask_reg) + (mem_rdata & mask_reg)) & mask_reg;

    // After the swap S[j] holds the old S[i] and S[i] the old S[j].
    always_comb
    begin
        if (t_reg == j_reg)
        begin
            st_sel = si_reg;
        end
        else if (t_reg == i_cur_reg)
        begin
            st_sel = sj_reg;
        end
        else
        begin
            st_sel = mem_rdata;
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = i_cur_reg;
        mem_wdata = mem_rdata;
        mem_re    = 1'b0;
        mem_raddr = i_use;
        case (state_reg)
            rc4kg_pkg::ST_RD_J:
            begin
                mem_re    = 1'b1;
                mem_raddr = j_calc;
            end
            rc4kg_pkg::ST_RD_T:
            begin
                mem_we    = 1'b1;
                mem_waddr = i_cur_reg;
                mem_wdata = mem_rdata;
                mem_re    = op_gen_reg;
                mem_raddr = t_calc;
            end
            rc4kg_pkg::ST_FIN:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                mem_wdata = si_reg;
            end
            rc4kg_pkg::ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = cnt_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
        if (do_key || do_gen)
        begin
            mem_re    = 1'b1;
            mem_raddr = i_use;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rc4kg_pkg::ST_IDLE, rc4kg_pkg::ST_FIN:
            begin
                if (state_reg == rc4kg_pkg::ST_FIN && !finish)
                begin
                    state_next = rc4kg_pkg::ST_FIN;
                end
                else if (do_init)
                begin
                    state_next = rc4kg_pkg::ST_FILL;
                end
                else if (do_key || do_gen)
                begin
                    state_next = rc4kg_pkg::ST_RD_J;
                end
                else
                begin
                    state_next = rc4kg_pkg::ST_IDLE;
                end
            end
            rc4kg_pkg::ST_RD_J:
            begin
                state_next = rc4kg_pkg::ST_RD_T;
            end
            rc4kg_pkg::ST_RD_T:
            begin
                state_next = rc4kg_pkg::ST_FIN;
            end
            rc4kg_pkg::ST_FILL:
            begin
                if (cnt_reg == '1)
                begin
                    state_next = rc4kg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rc4kg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish && op_gen_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rc4kg_pkg::ST_IDLE;
            mask_reg      <= mask_for(rc4kg_pkg::WORD_BITS_RESET);
            i_reg         <= '0;
            j_reg         <= '0;
            gen_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                mask_reg <= mask_for(cfg.word_bits);
            end
            if (do_init)
            begin
                i_reg   <= '0;
                j_reg   <= '0;
                gen_reg <= 1'b0;
            end
            else if (do_key)
            begin
                i_reg <= (i_use + AW'(1)) & mask_reg;
            end
            else if (do_gen)
            begin
                i_reg   <= i_use;
                gen_reg <= 1'b1;
                if (!gen_reg)
                begin
                    j_reg <= '0;
                end
            end
            else if (state_reg == rc4kg_pkg::ST_RD_J)
            begin
                j_reg <= j_calc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_key || do_gen)
        begin
            i_cur_reg  <= i_use;
            key_reg    <= AW'(in_ch.key_word);
            op_gen_reg <= do_gen;
        end
        if (do_init)
        begin
            cnt_reg <= '0;
        end
        else if (state_reg == rc4kg_pkg::ST_FILL)
        begin
            cnt_reg <= cnt_reg + AW'(1);
        end
        if (state_reg == rc4kg_pkg::ST_RD_J)
        begin
            si_reg <= mem_rdata;
        end
        if (state_reg == rc4kg_pkg::ST_RD_T)
        begin
            sj_reg <= mem_rdata;
            t_reg  <= t_calc;
        end
        if (finish && op_gen_reg)
        begin
            out_word_reg <= rc4kg_pkg::OUT_W'(st_sel & mask_reg);
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.keystream_word = out_word_reg;

    `ASSERT_IMPL(a_no_accept_mid_step,
        (state_reg == rc4kg_pkg::ST_RD_J) || (state_reg == rc4kg_pkg::ST_RD_T)
            || (state_reg == rc4kg_pkg::ST_FILL),
        !in_ch.ready)
    `ASSERT_NEXT(a_fill_ends_idle,
        (state_reg == rc4kg_pkg::ST_FILL) && (cnt_reg == '1),
        state_reg == rc4kg_pkg::ST_IDLE)
    `ASSERT_IMPL(a_no_write_when_idle,
        state_reg == rc4kg_pkg::ST_IDLE,
        !mem_we)
    `ASSERT_NEXT(a_gen_step_loads_output,
        finish && op_gen_reg,
        out_valid_reg)

endmodule

`default_nettype wire

// ===== sim/tb_rc4_keystream_generator.sv =====
`timescale 1ns / 1ps

module tb_rc4_keystream_generator;

    localparam int MAX_WORD_BITS  = 8;
    localparam int TABLE_SIZE     = 1 << MAX_WORD_BITS;
    localparam int RANDOM_WORDS   = 750;
    localparam int SETTLE_CYCLES  = TABLE_SIZE + 40;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam rc4kg_pkg::op_t OP_NONE = 2'd3;

    typedef struct {
        bit                  is_cfg;
        rc4kg_pkg::op_t      op;
        rc4kg_pkg::key_t     data;
        bit                  typed;
        rc4kg_pkg::ks_word_t want;
    } step_row_t;

    // Rows that carry a typed expectation follow directly from the identity table.
    step_row_t directed_rows [28] = '{
        '{1'b0, OP_NONE,            8'h3C, 1'b0, 8'd0},
        '{1'b0, rc4kg_pkg::OP_INIT, 8'h00, 1'b0, 8'd0},
        '{1'b0, rc4kg_pkg::OP_GEN,  8'h00, 1'b1, 8'd2},
        '{1'b0, rc4kg_pkg::OP_GEN,  8'hFF, 1'b1, 8'd5},
        '{1'b0, rc4kg_pkg::OP_KEY,  8'hFF, 1'b0, 8'd0},
        '{1'b0, rc4kg_pkg::OP_GEN,  8'h00, 1'b0, 8'd0},
        '{1'b0, rc4kg_pkg::OP_INIT, 8'hFF, 1'b0, 8'd0},
        '{1'b0, rc4kg_pkg::OP_KEY,  8'h00, 1'b0, 8'd0},
        '{1'b0, rc4kg_pkg::OP_KEY,  8'hFF, 1'b0, 8'd0},
        '{1'b0, rc4kg_pkg::OP_KEY,  8'hA5, 1'b0, 8'd0},
        '{1'b0, rc4kg_pkg::OP_GEN,  8'h5A, 1'b0, 8'd0},
        '{1'b0, OP_NONE,            8'hC3, 1'b0, 8'd0},
        '{1'b0, rc4kg_pkg::OP_GEN,  8'h00, 1'b0, 8'd0},
        '{1'b1, rc4kg_pkg::OP_INIT, 8'd3,  1'b0, 8'd0},
        '{1'b0, rc4kg_pkg::OP_GEN,  8'h81, 1'b0, 8'd0},
        '{1'b0, rc4kg_pkg::OP_KEY,  8'h7E, 1'b0, 8'd0},
        '{1'b0, rc4kg_pkg::OP_GEN,  8'h00, 1'b0, 8'd0},
        '{1'b1, rc4kg_pkg::OP_INIT, 8'd0,  1'b0, 8'd0},
        '{1'b0, rc4kg_pkg::OP_INIT, 8'h00, 1'b0, 8'd0},
        '{1'b0, rc4kg_pkg::OP_GEN,  8'h00, 1'b1, 8'd0},
        '{1'b0, rc4kg_pkg::OP_GEN,  8'hFF, 1'b0, 8'd0},
        '{1'b1, rc4kg_pkg::OP_INIT, 8'd15, 1'b0, 8'd0},
        '{1'b0, rc4kg_pkg::OP_INIT, 8'h00, 1'b0, 8'd0},
        '{1'b0, rc4kg_pkg::OP_GEN,  8'h00, 1'b1, 8'd2},
        '{1'b1, rc4kg_pkg::OP_INIT, 8'd1,  1'b0, 8'd0},
        '{1'b0, rc4kg_pkg::OP_INIT, 8'h00, 1'b0, 8'd0},
        '{1'b0, rc4kg_pkg::OP_KEY,  8'hFF, 1'b0, 8'd0},
        '{1'b0, rc4kg_pkg::OP_GEN,  8'h00, 1'b0, 8'd0}
    };

    rc4kg_pkg::word_bits_t wb_plan [16] = '{4'd1, 4'd8, 4'd2, 4'd0, 4'd4, 4'd15, 4'd3, 4'd8,
                                            4'd5, 4'd9, 4'd6, 4'd1, 4'd7, 4'd12, 4'd8, 4'd2};

    logic clk;
    logic rst_n;

    rc4kg_in_if  in_ch ();
    rc4kg_out_if out_ch ();
    rc4kg_cfg_if cfg_ch ();

    rc4_keystream_generator #(
        .MAX_WORD_BITS(MAX_WORD_BITS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .out_ch(out_ch),
        .cfg   (cfg_ch)
    );

    // Predicted cipher state.
    logic [7:0] sbox_q [TABLE_SIZE];
    logic [7:0] ks_i;
    logic [7:0] ks_j;
    bit         ks_generating;
    rc4kg_pkg::word_bits_t ks_word_bits;

    rc4kg_pkg::ks_word_t expected_words [$];
    int       mismatch_count;
    int       words_sent;
    int       stall_cycles;
    bit       quiet;
    bit       hold_req;

    always #6 clk = ~clk;

    task automatic report_mismatch(input string what, input rc4kg_pkg::ks_word_t got,
                                   input rc4kg_pkg::ks_word_t want);
        $display("[%0t] %s: got 0x%02h, expected 0x%02h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic cipher_step(input rc4kg_pkg::op_t op, input rc4kg_pkg::key_t key,
                               output bit produced, output rc4kg_pkg::ks_word_t word);
        int         n;
        logic [7:0] m;
        logic [7:0] swap_tmp;
        logic [7:0] t;
        n = int'(ks_word_bits);
        if (n < 1)
            n = 1;
        if (n > MAX_WORD_BITS)
            n = MAX_WORD_BITS;
        m = 8'((1 << n) - 1);
        produced = 1'b0;
        word = '0;
        case (op)
            rc4kg_pkg::OP_INIT:
            begin
                for (int k = 0; k < TABLE_SIZE; k++)
                    sbox_q[k] = 8'(k);
                ks_i = '0;
                ks_j = '0;
                ks_generating = 1'b0;
            end
            rc4kg_pkg::OP_KEY:
            begin
                if (!ks_generating)
                begin
                    ks_i = ks_i & m;
                    ks_j = (ks_j + (sbox_q[ks_i] & m) + key) & m;
                    swap_tmp = sbox_q[ks_i];
                    sbox_q[ks_i] = sbox_q[ks_j];
                    sbox_q[ks_j] = swap_tmp;
                    ks_i = (ks_i + 8'd1) & m;
                end
            end
            rc4kg_pkg::OP_GEN:
            begin
                if (!ks_generating)
                begin
                    ks_generating = 1'b1;
                    ks_i = '0;
                    ks_j = '0;
                end
                ks_i = (ks_i + 8'd1) & m;
                ks_j = (ks_j + (sbox_q[ks_i & m] & m)) & m;
                swap_tmp = sbox_q[ks_i & m];
                sbox_q[ks_i & m] = sbox_q[ks_j & m];
                sbox_q[ks_j & m] = swap_tmp;
                t = ((sbox_q[ks_i & m] & m) + (sbox_q[ks_j & m] & m)) & m;
                word = sbox_q[t] & m;
                produced = 1'b1;
            end
            default:
                ;
        endcase
    endtask

    task automatic send_word(input rc4kg_pkg::op_t op, input rc4kg_pkg::key_t key,
                             input bit typed, input rc4kg_pkg::ks_word_t want);
        bit                  produced;
        rc4kg_pkg::ks_word_t word;
        while (!quiet && $urandom_range(99) < 33)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.op       <= op;
        in_ch.key_word <= key;
        do
            @(posedge clk);
        while (!in_ch.ready);
        cipher_step(op, key, produced, word);
        if (produced)
            expected_words.push_back(typed ? want : word);
        words_sent++;
    endtask

    // Occasionally slips a stray word in ahead of the intended one.
    task automatic send_with_noise(input rc4kg_pkg::op_t op, input rc4kg_pkg::key_t key);
        int pick;
        pick = $urandom_range(0, 29);
        if (pick == 0)
            send_word(rc4kg_pkg::OP_INIT, 8'($urandom_range(255)), 1'b0, '0);
        else if (pick < 3)
            send_word(OP_NONE, 8'($urandom_range(255)), 1'b0, '0);
        else if (pick < 5)
            send_word(rc4kg_pkg::OP_KEY, 8'($urandom_range(255)), 1'b0, '0);
        send_word(op, key, 1'b0, '0);
    endtask

    // An init word gives no result, so the block may still be sweeping the
    // table when the last keystream word has arrived.
    task automatic write_word_bits(input rc4kg_pkg::word_bits_t value);
        in_ch.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.word_bits <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        ks_word_bits = value;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_words.size() == 0)
                report_mismatch("unexpected keystream word", out_ch.keystream_word, '0);
            else if (out_ch.keystream_word !== expected_words[0])
            begin
                report_mismatch("keystream_word", out_ch.keystream_word, expected_words[0]);
                void'(expected_words.pop_front());
            end
            else
                void'(expected_words.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                out_ch.ready <= quiet || ($urandom_range(99) >= 33);
        end
    end

    initial
    begin
        int              seg;
        int              n;
        int              key_len;
        int              steps;
        int              gens;
        rc4kg_pkg::key_t key_bytes [16];
        clk              = 1'b0;
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.op         = rc4kg_pkg::OP_INIT;
        in_ch.key_word   = '0;
        out_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.word_bits = '0;
        ks_i             = '0;
        ks_j             = '0;
        ks_generating    = 1'b0;
        ks_word_bits     = rc4kg_pkg::WORD_BITS_RESET;
        mismatch_count   = 0;
        words_sent       = 0;
        stall_cycles     = 0;
        quiet            = 1'b0;
        hold_req         = 1'b0;
        seg              = 0;
        for (int k = 0; k < TABLE_SIZE; k++)
            sbox_q[k] = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].is_cfg)
                write_word_bits(rc4kg_pkg::word_bits_t'(directed_rows[r].data));
            else
                send_word(directed_rows[r].op, directed_rows[r].data, directed_rows[r].typed,
                          directed_rows[r].want);
        end

        // Each pass: new word size, usually a fresh init, a key schedule that cycles
        // through a random key, then a run of keystream words.
        while (words_sent < RANDOM_WORDS + 23)
        begin
            quiet = (seg == 2 || seg == 3);
            write_word_bits(wb_plan[seg % 16]);
            n = int'(ks_word_bits);
            if (n < 1)
                n = 1;
            if (n > MAX_WORD_BITS)
                n = MAX_WORD_BITS;
            if (seg == 0 || $urandom_range(3) != 0)
                send_word(rc4kg_pkg::OP_INIT, 8'($urandom_range(255)), 1'b0, '0);
            key_len = $urandom_range(1, 16);
            for (int k = 0; k < key_len; k++)
                key_bytes[k] = 8'($urandom_range(255));
            steps = (n <= 5) ? (1 << n) : $urandom_range(4, 48);
            for (int s = 0; s < steps; s++)
                send_with_noise(rc4kg_pkg::OP_KEY, key_bytes[s % key_len]);
            if (seg == 5)
                hold_req = 1'b1;
            gens = $urandom_range(8, 40);
            for (int g = 0; g < gens; g++)
                send_with_noise(rc4kg_pkg::OP_GEN, 8'($urandom_range(255)));
            seg++;
        end
        quiet = 1'b0;
        in_ch.valid <= 1'b0;

        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/rc4kg_pkg.sv
hw/rtl/rc4kg_intf.sv
hw/rtl/rc4kg_perm_ram.sv
hw/rtl/rc4_keystream_generator.sv
sim/tb_rc4_keystream_generator.sv
